// ===== src/msv_pkg.sv =====
// Shared types, constants and helpers for the mesh file stream validator.
// Used by msv_core and mesh_file_stream_validator; depends on nothing else.
package msv_pkg;

	// Verdict codes, in the order of the status field
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_HEADER    = 3'd1,
		ST_BUDGET    = 3'd2,
		ST_LENGTH    = 3'd3,
		ST_NONFINITE = 3'd4,
		ST_POS_NRM   = 3'd5,
		ST_TEXCOORD  = 3'd6,
		ST_INDEX     = 3'd7
	} status_t;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VERTICES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_INDICES  = 2'd1;

	localparam int unsigned MAXV_W = 20;
	localparam int unsigned MAXI_W = 22;
	localparam int unsigned CFG_DATA_W = 22;
	localparam logic [MAXV_W-1:0] MAXV_RST = 20'd60000;
	localparam logic [MAXI_W-1:0] MAXI_RST = 22'd120000;

	// File layout
	localparam logic [31:0] POS_VCOUNT_END = 32'd11;
	localparam logic [31:0] POS_HDR_END    = 32'd15;
	localparam logic [31:0] SIG_LEN        = 32'd8;
	localparam logic [31:0] HDR_LEN        = 32'd16;
	localparam logic [31:0] IDX_START      = 32'd12;

	localparam logic [7:0] SIG_BYTES [8] = '{
		8'h44, 8'h4B, 8'h52, 8'h50, 8'h4D, 8'h30, 8'h30, 8'h31
	};

	// Magnitude limits on raw float bits (sign bit dropped)
	localparam logic [30:0] LIM_POS = 31'h40000000;
	localparam logic [30:0] LIM_NRM = 31'h3F8147AE;
	localparam logic [30:0] LIM_TEX = 31'h41800000;
	localparam logic [7:0]  EXP_ALL_ONES = 8'hFF;

	// Fields 0..2 position, 3..5 normal, 6..7 texture coordinate
	localparam logic [2:0] FIELD_NRM_FIRST = 3'd3;
	localparam logic [2:0] FIELD_TEX_FIRST = 3'd6;
	localparam logic [2:0] FIELD_LAST      = 3'd7;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_item_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] vertex_total;
		logic [31:0] index_total;
	} verdict_item_t;

	// Faults seen so far within one vertex record
	typedef struct packed {
		logic tex;
		logic pos_nrm;
		logic nonfinite;
	} vtx_faults_t;

	// Limits from the configuration registers
	typedef struct packed {
		logic [MAXV_W-1:0] max_vertices;
		logic [MAXI_W-1:0] max_indices;
	} budget_t;

	// Residue modulo 3 of a value up to 14 (4 = 1 mod 3, so fold 2-bit groups)
	function automatic logic [1:0] mod3_fold(input logic [3:0] x);
		logic [2:0] s;
		logic [2:0] t;
		s = {1'b0, x[3:2]} + {1'b0, x[1:0]};
		t = {2'b00, s[2]} + {1'b0, s[1:0]};
		mod3_fold = (t == 3'd3) ? 2'd0 : t[1:0];
	endfunction

endpackage

// ===== src/msv_core.sv =====
// Per-byte parsing state and verdict logic of the mesh file stream validator.
// Depends on msv_pkg.
module msv_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  msv_pkg::byte_item_t    item,
	input  msv_pkg::budget_t       budget,
	output msv_pkg::verdict_item_t verdict
);

	logic [31:0]          byte_count_q, byte_count_n;
	logic [31:0]          word_q, word_n;
	logic                 sig_ok_q, sig_ok_n;
	logic [31:0]          vcount_q, vcount_n;
	logic [31:0]          icount_q, icount_n;
	logic [31:0]          vend_q, vend_n;
	logic [31:0]          exp_len_q, exp_len_n;
	logic [1:0]           imod3_q, imod3_n;
	msv_pkg::vtx_faults_t faults_q, faults_n;
	msv_pkg::status_t     first_err_q, first_err_n;

	logic [31:0]          pos;
	logic [2:0]           field;
	logic [30:0]          mag;
	logic [30:0]          lim;
	msv_pkg::vtx_faults_t faults_acc;
	logic [36:0]          vend_sum;
	logic [37:0]          exp_sum;
	logic [3:0]           mod3_in;
	logic                 full;
	logic [31:0]          vt;
	logic [31:0]          it;

	assign pos = byte_count_q;
	// Field within the vertex record: (pos - 16) / 4 mod 8
	assign field = {~pos[4], pos[3:2]};
	assign mag = word_n[30:0];

	always_comb begin
		if (field < msv_pkg::FIELD_NRM_FIRST) begin
			lim = msv_pkg::LIM_POS;
		end else if (field < msv_pkg::FIELD_TEX_FIRST) begin
			lim = msv_pkg::LIM_NRM;
		end else begin
			lim = msv_pkg::LIM_TEX;
		end
	end

	// Float check on the word completed by this byte
	always_comb begin
		faults_acc = faults_q;
		if (word_n[30:23] == msv_pkg::EXP_ALL_ONES) begin
			faults_acc.nonfinite = 1'b1;
		end else if (mag > lim) begin
			if (field < msv_pkg::FIELD_TEX_FIRST) begin
				faults_acc.pos_nrm = 1'b1;
			end else begin
				faults_acc.tex = 1'b1;
			end
		end
	end

	// Header sums, saturated to 32 bits
	assign vend_sum = 37'(msv_pkg::HDR_LEN) + {vcount_q, 5'b0};
	assign exp_sum  = 38'(msv_pkg::HDR_LEN) + {1'b0, vcount_q, 5'b0} + {4'b0, word_n, 2'b0};
	assign mod3_in  = 4'({2'b00, imod3_q}) + 4'(item.data_byte[7:6]) + 4'(item.data_byte[5:4])
		+ 4'(item.data_byte[3:2]) + 4'(item.data_byte[1:0]);

	// Next stream state for the byte in hand
	always_comb begin
		word_n       = {item.data_byte, word_q[31:8]};
		byte_count_n = (byte_count_q == '1) ? byte_count_q : byte_count_q + 32'd1;
		sig_ok_n     = sig_ok_q;
		vcount_n     = vcount_q;
		icount_n     = icount_q;
		vend_n       = vend_q;
		exp_len_n    = exp_len_q;
		imod3_n      = imod3_q;
		faults_n     = faults_q;
		first_err_n  = first_err_q;

		if (pos >= msv_pkg::IDX_START && pos < msv_pkg::HDR_LEN) begin
			imod3_n = msv_pkg::mod3_fold(mod3_in);
		end

		if (pos < msv_pkg::SIG_LEN) begin
			if (item.data_byte != msv_pkg::SIG_BYTES[pos[2:0]]) begin
				sig_ok_n = 1'b0;
			end
		end else if (pos == msv_pkg::POS_VCOUNT_END) begin
			vcount_n = word_n;
		end else if (pos == msv_pkg::POS_HDR_END) begin
			icount_n  = word_n;
			vend_n    = (vend_sum[36:32] != '0) ? '1 : vend_sum[31:0];
			exp_len_n = (exp_sum[37:32] != '0) ? '1 : exp_sum[31:0];
		end else if (pos >= msv_pkg::HDR_LEN && pos[1:0] == 2'b11) begin
			if (pos < vend_q) begin
				if (field == msv_pkg::FIELD_LAST) begin
					faults_n = '0;
					if (first_err_q == msv_pkg::ST_OK) begin
						if (faults_acc.nonfinite) begin
							first_err_n = msv_pkg::ST_NONFINITE;
						end else if (faults_acc.pos_nrm) begin
							first_err_n = msv_pkg::ST_POS_NRM;
						end else if (faults_acc.tex) begin
							first_err_n = msv_pkg::ST_TEXCOORD;
						end
					end
				end else begin
					faults_n = faults_acc;
				end
			end else if (pos < exp_len_q) begin
				if (word_n >= vcount_q && first_err_q == msv_pkg::ST_OK) begin
					first_err_n = msv_pkg::ST_INDEX;
				end
			end
		end
	end

	// Verdict as it would stand if this byte ends the file
	assign full = (byte_count_n[31:4] != '0);
	assign vt   = full ? vcount_n : '0;
	assign it   = full ? icount_n : '0;

	always_comb begin
		verdict.vertex_total = vt;
		verdict.index_total  = it;
		if (!full || !sig_ok_n) begin
			verdict.status = msv_pkg::ST_HEADER;
		end else if (vt == '0 || vt > 32'(budget.max_vertices) || it == '0
				|| it > 32'(budget.max_indices) || imod3_n != 2'd0) begin
			verdict.status = msv_pkg::ST_BUDGET;
		end else if (byte_count_n != exp_len_n) begin
			verdict.status = msv_pkg::ST_LENGTH;
		end else begin
			verdict.status = first_err_n;
		end
	end

	// Stream state: cleared after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			word_q       <= '0;
			sig_ok_q     <= 1'b1;
			vcount_q     <= '0;
			icount_q     <= '0;
			vend_q       <= '0;
			exp_len_q    <= '0;
			imod3_q      <= '0;
			faults_q     <= '0;
			first_err_q  <= msv_pkg::ST_OK;
		end else if (step) begin
			if (item.last_byte) begin
				byte_count_q <= '0;
				word_q       <= '0;
				sig_ok_q     <= 1'b1;
				vcount_q     <= '0;
				icount_q     <= '0;
				vend_q       <= '0;
				exp_len_q    <= '0;
				imod3_q      <= '0;
				faults_q     <= '0;
				first_err_q  <= msv_pkg::ST_OK;
			end else begin
				byte_count_q <= byte_count_n;
				word_q       <= word_n;
				sig_ok_q     <= sig_ok_n;
				vcount_q     <= vcount_n;
				icount_q     <= icount_n;
				vend_q       <= vend_n;
				exp_len_q    <= exp_len_n;
				imod3_q      <= imod3_n;
				faults_q     <= faults_n;
				first_err_q  <= first_err_n;
			end
		end
	end

endmodule

// ===== src/mesh_file_stream_validator.sv =====
// Mesh file stream validator: one byte per cycle, one verdict per file.
// The final byte is held in the input register, and its verdict then in the verdict register until taken.
// Throughput: one byte per cycle; the input register is held only while a
// final byte waits behind a verdict not yet taken by the output side.
// Reset: limits return to 60000 vertices / 120000 indices, stream state cleared.
// Depends on msv_pkg and msv_core.
module mesh_file_stream_validator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             byte_valid,
	output logic                             byte_ready,
	input  msv_pkg::byte_item_t              byte_item,
	output logic                             verdict_valid,
	input  logic                             verdict_ready,
	output msv_pkg::verdict_item_t           verdict_item,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [msv_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [msv_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic                   valid_s1;
	msv_pkg::byte_item_t    item_s1;
	logic                   advance;
	logic                   step;
	msv_pkg::budget_t       budget_q;
	msv_pkg::verdict_item_t verdict;
	logic                   out_valid_q;
	msv_pkg::verdict_item_t out_q;

	// A final byte may move on only when the verdict register is free
	assign advance    = !(item_s1.last_byte && out_valid_q && !verdict_ready);
	assign step       = valid_s1 && advance;
	assign byte_ready = !valid_s1 || advance;
	assign cfg_ready  = 1'b1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			item_s1 <= byte_item;
		end
	end

	// Budget registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q.max_vertices <= msv_pkg::MAXV_RST;
			budget_q.max_indices  <= msv_pkg::MAXI_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				msv_pkg::REG_MAX_VERTICES: budget_q.max_vertices <= cfg_data[msv_pkg::MAXV_W-1:0];
				msv_pkg::REG_MAX_INDICES:  budget_q.max_indices  <= cfg_data[msv_pkg::MAXI_W-1:0];
				default: ;
			endcase
		end
	end

	msv_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.item    (item_s1),
		.budget  (budget_q),
		.verdict (verdict)
	);

	// Verdict register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && item_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (verdict_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && item_s1.last_byte) begin
			out_q <= verdict;
		end
	end

	assign verdict_valid = out_valid_q;
	assign verdict_item  = out_q;

endmodule

// ===== tb/mesh_file_stream_validator_tb.sv =====
// Self-checking bench for mesh_file_stream_validator: streams mesh files byte by byte and
// checks every verdict against a bit-exact predictor kept inside the bench.
// Depends on msv_pkg and the validator RTL only.
module mesh_file_stream_validator_tb;
	import msv_pkg::*;

	localparam int unsigned STALL_LIMIT   = 1000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned PHASE_BYTES   = 40;
	localparam int unsigned PHASE_FILES   = 1;

	// Register indexes that the block decodes to nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	// Kinds of float word the file builder can produce
	localparam int FLT_GOOD      = 0;
	localparam int FLT_EDGE      = 1;
	localparam int FLT_RANGE     = 2;
	localparam int FLT_NONFINITE = 3;
	localparam int NO_FIELD      = -1;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  byte_valid = 1'b0;
	logic                  byte_ready;
	byte_item_t            byte_item = '0;
	logic                  verdict_valid;
	logic                  verdict_ready = 1'b0;
	verdict_item_t         verdict_item;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	mesh_file_stream_validator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_item(byte_item),
		.verdict_valid(verdict_valid),
		.verdict_ready(verdict_ready),
		.verdict_item(verdict_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// Predictor state: limits plus per-file parse state
	logic [MAXV_W-1:0] lim_vertices = MAXV_RST;
	logic [MAXI_W-1:0] lim_indices  = MAXI_RST;
	logic [31:0]       seen_bytes   = '0;
	logic [31:0]       last_word    = '0;
	logic              sig_match    = 1'b1;
	logic [31:0]       hdr_vertices = '0;
	logic [31:0]       hdr_indices  = '0;
	logic [31:0]       vtx_end      = '0;
	logic [31:0]       file_len     = '0;
	vtx_faults_t       vtx_flags    = '0;
	status_t           first_fault  = ST_OK;

	verdict_item_t verdicts_due[$];
	verdict_item_t want_verdict;
	byte_item_t    pending_bytes[$];
	logic [7:0]    fbuf[$];
	int unsigned   n_queued = 0;
	int unsigned   n_taken = 0;
	int unsigned   errors = 0;

	// Traffic shaping
	logic          item_taken = 1'b0;
	logic          sender_steady = 1'b0;
	int unsigned   burst_left = 1;
	int unsigned   gap_left = 0;
	logic [15:0]   rcv_pattern = 16'hFFFF;
	logic [3:0]    rcv_slot = '0;

	function automatic logic [31:0] clip_u32(input logic [63:0] x);
		return (x > 64'hFFFFFFFF) ? 32'hFFFFFFFF : x[31:0];
	endfunction

	function automatic void note_fault(input status_t code);
		if (first_fault == ST_OK)
			first_fault = code;
	endfunction

	// Register write as the block sees it; unknown indexes fall through
	task automatic apply_limit(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_MAX_VERTICES: lim_vertices = d[MAXV_W-1:0];
			REG_MAX_INDICES:  lim_indices  = d[MAXI_W-1:0];
			default: ;
		endcase
	endtask

	// Per-byte parse; on the final byte work out the verdict and start afresh
	task automatic track_byte(input byte_item_t it);
		logic [31:0]   pos;
		logic [31:0]   rel;
		logic [2:0]    fld;
		logic [30:0]   lim;
		logic [63:0]   span;
		logic          full;
		verdict_item_t v;
		pos = seen_bytes;
		last_word = {it.data_byte, last_word[31:8]};
		if (seen_bytes != 32'hFFFFFFFF)
			seen_bytes++;
		if (pos < SIG_LEN) begin
			if (it.data_byte != SIG_BYTES[pos[2:0]])
				sig_match = 1'b0;
		end else if (pos == POS_VCOUNT_END) begin
			hdr_vertices = last_word;
		end else if (pos == POS_HDR_END) begin
			hdr_indices = last_word;
			span = 64'd16 + 64'd32 * hdr_vertices;
			vtx_end = clip_u32(span);
			file_len = clip_u32(span + 64'd4 * hdr_indices);
		end else if (pos >= HDR_LEN) begin
			rel = pos - HDR_LEN;
			if (rel[1:0] == 2'd3) begin
				if (pos < vtx_end) begin
					// one float of a vertex record
					fld = rel[4:2];
					lim = (fld < FIELD_NRM_FIRST) ? LIM_POS :
						(fld < FIELD_TEX_FIRST) ? LIM_NRM : LIM_TEX;
					if (last_word[30:23] == EXP_ALL_ONES)
						vtx_flags.nonfinite = 1'b1;
					else if (last_word[30:0] > lim) begin
						if (fld < FIELD_TEX_FIRST)
							vtx_flags.pos_nrm = 1'b1;
						else
							vtx_flags.tex = 1'b1;
					end
					if (fld == FIELD_LAST) begin
						if (vtx_flags.nonfinite)
							note_fault(ST_NONFINITE);
						else if (vtx_flags.pos_nrm)
							note_fault(ST_POS_NRM);
						else if (vtx_flags.tex)
							note_fault(ST_TEXCOORD);
						vtx_flags = '0;
					end
				end else if (pos < file_len) begin
					if (last_word >= hdr_vertices)
						note_fault(ST_INDEX);
				end
			end
		end
		if (it.last_byte) begin
			full = (seen_bytes >= HDR_LEN);
			v.vertex_total = full ? hdr_vertices : 32'd0;
			v.index_total = full ? hdr_indices : 32'd0;
			if (!full || !sig_match)
				v.status = ST_HEADER;
			else if (v.vertex_total == 0 || v.vertex_total > lim_vertices ||
				v.index_total == 0 || v.index_total > lim_indices ||
				(v.index_total % 3) != 0)
				v.status = ST_BUDGET;
			else if (seen_bytes != file_len)
				v.status = ST_LENGTH;
			else
				v.status = first_fault;
			verdicts_due.insert(verdicts_due.size(), v);
			seen_bytes = '0;
			last_word = '0;
			sig_match = 1'b1;
			hdr_vertices = '0;
			hdr_indices = '0;
			vtx_end = '0;
			file_len = '0;
			vtx_flags = '0;
			first_fault = ST_OK;
		end
	endtask

	// File builder
	task automatic add_byte(input logic [7:0] b);
		fbuf.insert(fbuf.size(), b);
	endtask

	task automatic put_word(input logic [31:0] w);
		for (int k = 0; k < 4; k++)
			add_byte(w[8*k +: 8]);
	endtask

	task automatic put_header(input logic sig_good, input logic [31:0] nv, input logic [31:0] ni);
		int unsigned base;
		base = fbuf.size();
		for (int k = 0; k < 8; k++)
			add_byte(SIG_BYTES[k]);
		if (!sig_good)
			fbuf[base + $urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
		put_word(nv);
		put_word(ni);
	endtask

	task automatic put_float(input int fld, input int kind);
		logic [30:0] lim;
		logic [30:0] mag;
		logic        sgn;
		lim = (fld < FIELD_NRM_FIRST) ? LIM_POS : (fld < FIELD_TEX_FIRST) ? LIM_NRM : LIM_TEX;
		sgn = 1'($urandom_range(0, 1));
		case (kind)
			FLT_EDGE:      mag = lim;
			FLT_RANGE:     mag = ($urandom_range(0, 3) == 0) ? lim + 31'd1 :
				31'(lim + 1 + ($urandom % (31'h7F7FFFFF - lim)));
			FLT_NONFINITE: mag = {EXP_ALL_ONES, 23'($urandom)};
			default:       mag = ($urandom_range(0, 7) == 0) ? 31'd0 : 31'($urandom % (lim + 1));
		endcase
		put_word({sgn, mag});
	endtask

	// Vertex with up to two chosen faults, the rest in range
	task automatic put_vertex(input int fa, input int ka, input int fb, input int kb);
		for (int f = 0; f < 8; f++)
			put_float(f, (f == fa) ? ka : (f == fb) ? kb : FLT_GOOD);
	endtask

	task automatic random_vertex(input int unsigned pct);
		int unsigned r;
		for (int f = 0; f < 8; f++) begin
			r = $urandom_range(0, 99);
			if (r < pct)
				put_float(f, $urandom_range(FLT_RANGE, FLT_NONFINITE));
			else if (r < pct + 5)
				put_float(f, FLT_EDGE);
			else
				put_float(f, FLT_GOOD);
		end
	endtask

	task automatic random_index(input logic [31:0] nv, input int unsigned pct);
		if ($urandom_range(0, 99) < pct) begin
			case ($urandom_range(0, 2))
				0:       put_word(nv);
				1:       put_word(nv + $urandom_range(1, 1000));
				default: put_word(32'hFFFFFFFF);
			endcase
		end else begin
			put_word((nv == 0) ? $urandom : $urandom % nv);
		end
	endtask

	// Mostly well-formed meshes with random content, the rest broken or noise
	task automatic random_mesh();
		int unsigned kind;
		int unsigned cap_v;
		int unsigned cap_t;
		int unsigned pct;
		int unsigned cut;
		logic [31:0] nv;
		logic [31:0] ni;
		kind = $urandom_range(0, 99);
		cap_v = (lim_vertices < 3) ? lim_vertices : 3;
		if (cap_v == 0)
			cap_v = 1;
		cap_t = lim_indices / 3;
		if (cap_t > 4)
			cap_t = 4;
		if (cap_t == 0)
			cap_t = 1;
		nv = $urandom_range(1, cap_v);
		ni = 3 * $urandom_range(1, cap_t);
		pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
		if (kind >= 90) begin
			repeat ($urandom_range(1, 40))
				add_byte(8'($urandom));
		end else begin
			if (kind >= 82) begin
				case ($urandom_range(0, 4))
					0:       nv = 0;
					1:       ni = ni + $urandom_range(1, 2);
					2:       nv = lim_vertices + 1;
					3:       ni = lim_indices + 1;
					default: begin
						nv = $urandom;
						ni = $urandom;
					end
				endcase
			end
			put_header(!(kind >= 76 && kind < 82), nv, ni);
			if (nv <= 8 && ni <= 16) begin
				for (int k = 0; k < nv; k++)
					random_vertex(pct);
				for (int k = 0; k < ni; k++)
					random_index(nv, pct);
			end else begin
				repeat ($urandom_range(0, 20))
					add_byte(8'($urandom));
			end
			// length off in either direction, short files included
			if (kind >= 66 && kind < 76) begin
				if ($urandom_range(0, 1)) begin
					repeat ($urandom_range(1, 6))
						add_byte(8'($urandom));
				end else begin
					cut = $urandom_range(1, (fbuf.size() > 41) ? 40 : fbuf.size() - 1);
					repeat (cut)
						void'(fbuf.pop_back());
				end
			end
		end
	endtask

	// Hand the built file to the driver, end mark on its final byte
	task automatic ship_file();
		byte_item_t it;
		foreach (fbuf[k]) begin
			it.data_byte = fbuf[k];
			it.last_byte = (k == fbuf.size() - 1);
			pending_bytes.insert(pending_bytes.size(), it);
			n_queued++;
		end
		fbuf.delete();
	endtask

	task automatic clean_mesh(input logic [31:0] nv, input logic [31:0] ni);
		put_header(1'b1, nv, ni);
		for (int k = 0; k < nv; k++)
			put_vertex(NO_FIELD, FLT_GOOD, NO_FIELD, FLT_GOOD);
		for (int k = 0; k < ni; k++)
			put_word(k % nv);
	endtask

	task automatic drain();
		while (n_taken != n_queued || verdicts_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic settle();
		drain();
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input logic pressure);
		int unsigned start;
		int unsigned files;
		start = n_queued;
		files = 0;
		while (n_queued - start < PHASE_BYTES || files < PHASE_FILES) begin
			random_mesh();
			ship_file();
			files++;
			// let the pipe run dry now and then
			if (pressure && $urandom_range(0, 3) == 0)
				drain();
		end
	endtask

	// Byte sender: bursts with random gaps, unless set steady
	always @(negedge clk) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
		end else if (!byte_valid || item_taken) begin
			if (gap_left != 0) begin
				gap_left--;
				byte_valid <= 1'b0;
			end else if (pending_bytes.size() == 0) begin
				byte_valid <= 1'b0;
			end else begin
				byte_item <= pending_bytes.pop_front();
				byte_valid <= 1'b1;
				burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 30);
					if (!sender_steady)
						gap_left = $urandom_range(1, 10);
				end
			end
		end
	end

	// Verdict sink: ready follows a rotating pattern
	always @(negedge clk) begin
		if (!arst_n) begin
			verdict_ready <= 1'b0;
		end else begin
			verdict_ready <= rcv_pattern[rcv_slot];
			rcv_slot <= rcv_slot + 4'd1;
		end
	end

	// Monitor: predict on accepted bytes and writes, check accepted verdicts
	always @(posedge clk) begin
		item_taken <= byte_valid && byte_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				apply_limit(cfg_index, cfg_data);
			if (byte_valid && byte_ready) begin
				track_byte(byte_item);
				n_taken++;
			end
			if (verdict_valid && verdict_ready) begin
				if (verdicts_due.size() == 0) begin
					$error("verdict with none expected: status %0d", verdict_item.status);
					errors++;
				end else begin
					want_verdict = verdicts_due.pop_front();
					if (verdict_item.status !== want_verdict.status) begin
						$error("status: expected %0d, got %0d",
							want_verdict.status, verdict_item.status);
						errors++;
					end
					if (verdict_item.vertex_total !== want_verdict.vertex_total) begin
						$error("vertex_total: expected %0d, got %0d",
							want_verdict.vertex_total, verdict_item.vertex_total);
						errors++;
					end
					if (verdict_item.index_total !== want_verdict.index_total) begin
						$error("index_total: expected %0d, got %0d",
							want_verdict.index_total, verdict_item.index_total);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog on cycles with no handshake at all
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((byte_valid && byte_ready) || (verdict_valid && verdict_ready) ||
				(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		repeat (11)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset limits; directed cases first
		rcv_pattern = 16'($urandom) | 16'h0001;
		sender_steady = 1'b0;
		// short headers: a single byte, then fifteen
		add_byte(SIG_BYTES[0]);
		ship_file();
		put_header(1'b1, 32'd1, 32'd3);
		void'(fbuf.pop_back());
		ship_file();
		// minimal clean mesh, then the same with a bad signature
		clean_mesh(32'd1, 32'd3);
		ship_file();
		put_header(1'b0, 32'd1, 32'd3);
		put_vertex(NO_FIELD, FLT_GOOD, NO_FIELD, FLT_GOOD);
		repeat (3)
			put_word(32'd0);
		ship_file();
		// budget: zero vertices, indices not in triangles, over limits, saturating counts
		put_header(1'b1, 32'd0, 32'd3);
		ship_file();
		clean_mesh(32'd1, 32'd4);
		ship_file();
		put_header(1'b1, 32'd60001, 32'd3);
		ship_file();
		put_header(1'b1, 32'd1, 32'd120003);
		ship_file();
		put_header(1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF);
		ship_file();
		// length one byte short and one byte long
		clean_mesh(32'd1, 32'd3);
		void'(fbuf.pop_back());
		ship_file();
		clean_mesh(32'd1, 32'd3);
		add_byte(8'hFF);
		ship_file();
		// every float exactly at its limit
		put_header(1'b1, 32'd1, 32'd3);
		for (int f = 0; f < 8; f++)
			put_float(f, FLT_EDGE);
		repeat (3)
			put_word(32'd0);
		ship_file();
		// over the limit: position, normal, texture coordinate
		for (int k = 0; k < 3; k++) begin
			put_header(1'b1, 32'd1, 32'd3);
			put_vertex(k == 0 ? 0 : k == 1 ? 3 : 7, FLT_RANGE, NO_FIELD, FLT_GOOD);
			repeat (3)
				put_word(32'd0);
			ship_file();
		end
		// non-finite beats range, position/normal beats texcoord in one vertex
		put_header(1'b1, 32'd1, 32'd3);
		put_vertex(7, FLT_NONFINITE, 1, FLT_RANGE);
		repeat (3)
			put_word(32'd0);
		ship_file();
		put_header(1'b1, 32'd1, 32'd3);
		put_vertex(6, FLT_RANGE, 4, FLT_RANGE);
		repeat (3)
			put_word(32'd0);
		ship_file();
		// first fault in file order wins across vertices
		put_header(1'b1, 32'd2, 32'd3);
		put_vertex(6, FLT_RANGE, NO_FIELD, FLT_GOOD);
		put_vertex(0, FLT_NONFINITE, NO_FIELD, FLT_GOOD);
		put_word(32'd0);
		put_word(32'd1);
		put_word(32'd1);
		ship_file();
		// index equal to the vertex count; vertex fault ahead of a bad index
		clean_mesh(32'd2, 32'd3);
		void'(fbuf.pop_back());
		void'(fbuf.pop_back());
		void'(fbuf.pop_back());
		void'(fbuf.pop_back());
		put_word(32'd2);
		ship_file();
		put_header(1'b1, 32'd2, 32'd6);
		put_vertex(2, FLT_RANGE, NO_FIELD, FLT_GOOD);
		put_vertex(NO_FIELD, FLT_GOOD, NO_FIELD, FLT_GOOD);
		put_word(32'd0);
		put_word(32'd1);
		put_word(32'hFFFFFFFF);
		put_word(32'd1);
		put_word(32'd0);
		put_word(32'd1);
		ship_file();
		settle();

		// Smallest limits, sender steady, receiver always ready
		write_limit(REG_MAX_VERTICES, 22'd1);
		write_limit(REG_MAX_INDICES, 22'd3);
		sender_steady = 1'b1;
		rcv_pattern = 16'hFFFF;
		clean_mesh(32'd1, 32'd3);
		ship_file();
		clean_mesh(32'd2, 32'd3);
		ship_file();
		clean_mesh(32'd1, 32'd6);
		ship_file();
		random_phase(1'b0);
		settle();

		// Largest limits, spare indexes ignored; sender waits for verdicts at times
		write_limit(REG_MAX_VERTICES, 22'h3FFFFF);
		write_limit(REG_MAX_INDICES, 22'h3FFFFF);
		write_limit(REG_SPARE_A, 22'($urandom));
		write_limit(REG_SPARE_B, 22'($urandom));
		sender_steady = 1'b0;
		rcv_pattern = 16'($urandom) | 16'h0001;
		put_header(1'b1, 32'd1048575, 32'd3);
		ship_file();
		put_header(1'b1, 32'd1048576, 32'd3);
		ship_file();
		put_header(1'b1, 32'd1, 32'd4194303);
		ship_file();
		put_header(1'b1, 32'd1, 32'd4194306);
		ship_file();
		random_phase(1'b1);
		settle();

		// Random limits
		write_limit(REG_MAX_VERTICES, 22'($urandom));
		write_limit(REG_MAX_INDICES, 22'($urandom));
		rcv_pattern = 16'($urandom) | 16'h0001;
		random_phase(1'b0);
		settle();

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
